>>> sv/bcps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bezier closest parameter search: shared package
// Widths, fixed-point types and the rounded interpolation used by the
// de Casteljau stages.
// ----------------------------------------------------------------------------
package bcps_pkg;

  localparam int HALVING_STEPS = 12;
  localparam int COORD_BITS    = 16;
  localparam int CURVE_ORDER   = 3;
  localparam int NPTS          = CURVE_ORDER + 1;
  localparam int IN_BITS       = 16;
  localparam int FRAC_BITS     = 31 - COORD_BITS;
  localparam int FIX_W         = COORD_BITS + FRAC_BITS + 1;
  localparam int T_BITS        = 16;
  localparam int PROD_W        = FIX_W + T_BITS + 2;
  localparam int DIST_W        = 2 * FIX_W;
  localparam int STAGE_DEPTH   = 5;
  localparam int LATENCY       = STAGE_DEPTH * HALVING_STEPS;
  localparam int ROUND_HALF    = 1 << (T_BITS - 1);
  localparam int CFG_IDX_W     = $clog2(2 * NPTS);
  localparam int PT_IDX_W      = $clog2(NPTS);
  localparam int AXIS_X        = 0;
  localparam int AXIS_Y        = 1;
  localparam int END_LEFT      = 0;
  localparam int END_RIGHT     = 1;

  typedef logic signed [IN_BITS-1:0]    coord_in_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [FIX_W-1:0]      fix_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic [T_BITS:0]              tpar_t;
  typedef logic [DIST_W-1:0]            dist_t;
  typedef fix_t                         ctrl_set_t [2][NPTS];

  localparam tpar_t T_ONE = tpar_t'(1 << T_BITS);

  typedef struct packed {
    fix_t  rx;
    fix_t  ry;
    tpar_t left;
    tpar_t right;
  } search_t;

  function automatic fix_t to_fix(coord_in_t v);
    coord_t c;
    c = coord_t'(v);
    return fix_t'(c) <<< FRAC_BITS;
  endfunction

  function automatic fix_t lerp(fix_t a, fix_t b, tpar_t t);
    prod_t d;
    prod_t p;
    d = prod_t'(b) - prod_t'(a);
    p = d * prod_t'({1'b0, t}) + prod_t'(ROUND_HALF);
    return a + fix_t'(p >>> T_BITS);
  endfunction

  function automatic tpar_t midpoint(tpar_t l, tpar_t r);
    logic [T_BITS+1:0] s;
    s = {1'b0, l} + {1'b0, r};
    return s[T_BITS+1:1];
  endfunction

endpackage
`default_nettype wire

>>> sv/bcps_halving.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bezier closest parameter search: one halving step
// Evaluates the curve at both interval ends over three registered de Casteljau
// levels, squares distances, moves the farther end (right on tie) to midpoint.
// ----------------------------------------------------------------------------
module bcps_halving (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire bcps_pkg::ctrl_set_t ctrl_i,
  input  wire logic                valid_i,
  input  wire bcps_pkg::search_t   search_i,
  output logic                     valid_o,
  output bcps_pkg::search_t        search_o
);

  logic [bcps_pkg::STAGE_DEPTH-1:0] v_q;
  bcps_pkg::search_t s1_q, s2_q, s3_q, s4_q, s5_q;
  bcps_pkg::fix_t  w1_d [2][2][3];
  bcps_pkg::fix_t  w1_q [2][2][3];
  bcps_pkg::fix_t  w2_d [2][2][2];
  bcps_pkg::fix_t  w2_q [2][2][2];
  bcps_pkg::fix_t  pt_d [2][2];
  bcps_pkg::fix_t  pt_q [2][2];
  bcps_pkg::dist_t sq_d [2][2];
  bcps_pkg::dist_t sq_q [2][2];
  bcps_pkg::search_t s5_d;

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      for (int a = 0; a < 2; a++) begin
        for (int i = 0; i < 3; i++) begin
          w1_d[e][a][i] = bcps_pkg::lerp(ctrl_i[a][i], ctrl_i[a][i+1],
              (e == bcps_pkg::END_LEFT) ? search_i.left : search_i.right);
        end
        for (int i = 0; i < 2; i++) begin
          w2_d[e][a][i] = bcps_pkg::lerp(w1_q[e][a][i], w1_q[e][a][i+1],
              (e == bcps_pkg::END_LEFT) ? s1_q.left : s1_q.right);
        end
        pt_d[e][a] = bcps_pkg::lerp(w2_q[e][a][0], w2_q[e][a][1],
            (e == bcps_pkg::END_LEFT) ? s2_q.left : s2_q.right);
      end
    end
  end

  always_comb begin
    bcps_pkg::fix_t diff;
    logic [bcps_pkg::FIX_W-1:0] mag;
    for (int e = 0; e < 2; e++) begin
      for (int a = 0; a < 2; a++) begin
        diff = pt_q[e][a] - ((a == bcps_pkg::AXIS_X) ? s3_q.rx : s3_q.ry);
        mag  = diff[bcps_pkg::FIX_W-1] ? (-diff) : diff;
        sq_d[e][a] = bcps_pkg::DIST_W'(mag) * bcps_pkg::DIST_W'(mag);
      end
    end
  end

  always_comb begin
    bcps_pkg::dist_t dl;
    bcps_pkg::dist_t dr;
    bcps_pkg::tpar_t mid;
    dl   = sq_q[bcps_pkg::END_LEFT][0] + sq_q[bcps_pkg::END_LEFT][1];
    dr   = sq_q[bcps_pkg::END_RIGHT][0] + sq_q[bcps_pkg::END_RIGHT][1];
    mid  = bcps_pkg::midpoint(s4_q.left, s4_q.right);
    s5_d = s4_q;
    if (dr < dl) begin
      s5_d.left = mid;
    end else begin
      s5_d.right = mid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[bcps_pkg::STAGE_DEPTH-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= search_i;
    s2_q <= s1_q;
    s3_q <= s2_q;
    s4_q <= s3_q;
    s5_q <= s5_d;
    w1_q <= w1_d;
    w2_q <= w2_d;
    pt_q <= pt_d;
    sq_q <= sq_d;
  end

  assign valid_o  = v_q[bcps_pkg::STAGE_DEPTH-1];
  assign search_o = s5_q;

endmodule
`default_nettype wire

>>> sv/bezier_closest_param_search_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bezier closest parameter search core
// Returns the parameter of the curve point nearest to a robot position.
// ----------------------------------------------------------------------------
// A request is taken in every clock cycle in which start is high; busy is
// never raised. Each request gives one result on curve_param_o, marked by
// done_o for a single cycle. Each of the twelve halvings has five register
// stages: three interpolation levels, the squaring
// multipliers and the compare. Results leave in request order and must be
// taken when shown. Control points are written through the cfg port; the user
// must do so only while no request is in flight; the block does not check it.
module bezier_closest_param_search_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [bcps_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [bcps_pkg::IN_BITS-1:0]     cfg_wdata_i,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic signed [bcps_pkg::IN_BITS-1:0] robot_x_i,
  input  wire logic signed [bcps_pkg::IN_BITS-1:0] robot_y_i,
  output logic                                  done_o,
  output logic [bcps_pkg::T_BITS-1:0]           curve_param_o
);

  bcps_pkg::ctrl_set_t ctrl_q;
  logic               valid_c [bcps_pkg::HALVING_STEPS+1];
  bcps_pkg::search_t  search_c [bcps_pkg::HALVING_STEPS+1];
  bcps_pkg::tpar_t    result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 2; a++) begin
        for (int i = 0; i < bcps_pkg::NPTS; i++) begin
          ctrl_q[a][i] <= '0;
        end
      end
    end else if (cfg_we_i) begin
      ctrl_q[cfg_idx_i[bcps_pkg::CFG_IDX_W-1]][cfg_idx_i[bcps_pkg::PT_IDX_W-1:0]] <=
          bcps_pkg::to_fix(cfg_wdata_i);
    end
  end

  assign busy = 1'b0;

  assign valid_c[0]        = start;
  assign search_c[0].rx    = bcps_pkg::to_fix(robot_x_i);
  assign search_c[0].ry    = bcps_pkg::to_fix(robot_y_i);
  assign search_c[0].left  = '0;
  assign search_c[0].right = bcps_pkg::T_ONE;

  for (genvar g = 0; g < bcps_pkg::HALVING_STEPS; g++) begin : g_step
    bcps_halving u_halving (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl_q),
      .valid_i  (valid_c[g]),
      .search_i (search_c[g]),
      .valid_o  (valid_c[g+1]),
      .search_o (search_c[g+1])
    );
  end

  assign result = bcps_pkg::midpoint(search_c[bcps_pkg::HALVING_STEPS].left,
                                     search_c[bcps_pkg::HALVING_STEPS].right);
  assign done_o        = valid_c[bcps_pkg::HALVING_STEPS];
  assign curve_param_o = result[bcps_pkg::T_BITS-1:0];

endmodule
`default_nettype wire

>>> sv/bcps_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bezier closest parameter search: port checker
// Checks latency, the never-busy request port and the result grid.
// ----------------------------------------------------------------------------
module bcps_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          done_o,
  input wire logic [bcps_pkg::T_BITS-1:0]   curve_param_o
);

  localparam int GRID = 1 << (bcps_pkg::T_BITS - bcps_pkg::HALVING_STEPS - 1);
  localparam logic [bcps_pkg::T_BITS-1:0] LOW_MASK = bcps_pkg::T_BITS'(GRID - 1);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_req_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (start && !busy) |-> ##(bcps_pkg::LATENCY) done_o)
    else $error("request without result");

  a_result_had_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_o |-> $past(start && !busy, bcps_pkg::LATENCY))
    else $error("result without request");

  a_result_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_o |-> ((curve_param_o & LOW_MASK) == '0))
    else $error("result off the halving grid");

endmodule

bind bezier_closest_param_search_core bcps_checker u_bcps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .curve_param_o (curve_param_o)
);
`default_nettype wire
